@@ rtl/msma_pkg.sv @@
// ----------------------------------------------------------------------------
// msma_pkg: shared definitions for the SMA based MACD crossover indicator
// Field widths, register indexes, reset values, decision codes and the
// bit positions of the output stream fields.
// ----------------------------------------------------------------------------
package msma_pkg;

	// Field widths fixed by the item formats.
	localparam int PRICE_W      = 32;
	localparam int MACD_W       = 33;
	localparam int WIN_LEN_W    = 7;
	localparam int SIG_LEN_W    = 6;
	localparam int DEC_W        = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_LEN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_LEN = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [WIN_LEN_W-1:0] FAST_LEN_RST   = 7'd12;
	localparam logic [WIN_LEN_W-1:0] SLOW_LEN_RST   = 7'd26;
	localparam logic [SIG_LEN_W-1:0] SIGNAL_LEN_RST = 6'd9;

	// Decision codes.
	localparam logic [DEC_W-1:0] DEC_HOLD = 2'd0;
	localparam logic [DEC_W-1:0] DEC_BUY  = 2'd1;
	localparam logic [DEC_W-1:0] DEC_SELL = 2'd2;

	// Output tdata layout, lowest bit first, padded to whole bytes.
	localparam int OUT_MACD_LSB = 0;
	localparam int OUT_SIG_LSB  = OUT_MACD_LSB + MACD_W;
	localparam int OUT_DEC_LSB  = OUT_SIG_LSB + MACD_W;
	localparam int OUT_DATA_W   = ((OUT_DEC_LSB + DEC_W + 7) / 8) * 8;

	// Output tuser layout.
	localparam int OUT_USER_W     = 2;
	localparam int USER_MACD_VLD  = 0;
	localparam int USER_SIG_VLD   = 1;

endpackage

@@ rtl/msma_ram.sv @@
// ----------------------------------------------------------------------------
// msma_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module msma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/msma_div.sv @@
// ----------------------------------------------------------------------------
// msma_div: iterative unsigned restoring divider
// Produces one quotient bit per cycle; done pulses for one cycle when the
// quotient is ready.
// ----------------------------------------------------------------------------
module msma_div #(
	parameter int DW = 38,
	parameter int VW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VW:0]      trial;
	logic             fits;

	// Shift the next dividend bit into the partial remainder and try it.
	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	// Control: step counter, busy and the done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= VW'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[VW-1:0];
			end
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/sma_macd_crossover_signal.sv @@
// ----------------------------------------------------------------------------
// sma_macd_crossover_signal: MACD indicator built from simple moving averages
// Keeps a price ring and a MACD ring in RAM and gives MACD, signal line and
// a buy, sell or hold decision for each price tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one unsigned Q16.16 price per transaction. For each price
//   the block returns exactly one result transaction on m_axis: MACD value,
//   signal value and decision in tdata, the two valid flags in tuser.
//   The cfg channel writes the fast, slow and signal window lengths
//   (index 0, 1, 2); it is always ready and should be used while idle.
// Sequence:
//   One tick is worked on at a time. A tick with both values valid reads
//   the price window, divides for the fast and the slow average, writes the
//   MACD ring, reads the MACD window and divides for the signal line. The
//   divider is DIV_W bits wide (38 at default parameters). A tick with only
//   the MACD valid skips the MACD window read and the signal division; a tick
//   before the windows fill only writes the MACD ring. The windows are read
//   one RAM word per cycle and each division is one pass through the
//   one-bit-per-cycle divider. The next price can be taken in the same cycle
//   in which the result is first offered.
// Reset:
//   arst_n clears the control state, tick counter and ring pointers and
//   restores the lengths to 12, 26 and 9. RAM contents are not cleared.
// Stall:
//   A finished result waits in the output register while m_axis_tready is
//   low; the next price is still taken, and its result waits until the
//   output register is free.
// ----------------------------------------------------------------------------
module sma_macd_crossover_signal #(
	parameter int MAX_WINDOW = 64,
	parameter int MAX_SIGNAL = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Price stream.
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [msma_pkg::PRICE_W-1:0]          s_axis_tdata,  // [31:0] price
	// Result stream.
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [32:0] macd_value, [65:33] signal_value, [67:66] decision, [71:68] zero
	output logic [msma_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// [0] macd_valid, [1] signal_valid
	output logic [msma_pkg::OUT_USER_W-1:0]       m_axis_tuser,
	// Configuration write channel.
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [msma_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [msma_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int PRICE_W  = msma_pkg::PRICE_W;
	localparam int MACD_W   = msma_pkg::MACD_W;
	localparam int PAW      = $clog2(MAX_WINDOW);
	localparam int MAW      = (MAX_SIGNAL > 1) ? $clog2(MAX_SIGNAL) : 1;
	localparam int LEN_W    = $clog2(MAX_WINDOW + 1);
	localparam int GLEN_W   = $clog2(MAX_SIGNAL + 1);
	localparam int SUM_W    = PRICE_W + $clog2(MAX_WINDOW);
	localparam int MSUM_W   = MACD_W + $clog2(MAX_SIGNAL);
	localparam int DIV_W    = (SUM_W > MSUM_W) ? SUM_W : MSUM_W;
	localparam int VW       = (LEN_W > GLEN_W) ? LEN_W : GLEN_W;
	localparam int TICK_MAX = MAX_WINDOW + MAX_SIGNAL - 1;
	localparam int TW       = $clog2(TICK_MAX + 1);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PSUM = 3'd1;
	localparam logic [2:0] ST_DIVF = 3'd2;
	localparam logic [2:0] ST_DIVS = 3'd3;
	localparam logic [2:0] ST_MWR  = 3'd4;
	localparam logic [2:0] ST_MSUM = 3'd5;
	localparam logic [2:0] ST_DIVG = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0]                      state_q;

	logic [msma_pkg::WIN_LEN_W-1:0]  fast_len_q;
	logic [msma_pkg::WIN_LEN_W-1:0]  slow_len_q;
	logic [msma_pkg::SIG_LEN_W-1:0]  signal_len_q;

	logic [PAW-1:0]                  phead_q;
	logic [MAW-1:0]                  mhead_q;
	logic [PAW-1:0]                  prptr_q;
	logic [MAW-1:0]                  mrptr_q;
	logic [TW-1:0]                   tick_q;

	logic [LEN_W-1:0]                fl_c, sl_c, big_c;
	logic [GLEN_W-1:0]               gl_c;
	logic                            mv_c, sv_c;

	logic [LEN_W-1:0]                fl_q, sl_q, big_q;
	logic [GLEN_W-1:0]               gl_q;
	logic                            mv_q, sv_q;

	logic [VW-1:0]                   rd_cnt_q;
	logic [VW-1:0]                   dk_q;
	logic                            pend_q;
	logic                            issue;
	logic                            sum_done;

	logic [SUM_W-1:0]                fast_sum_q, slow_sum_q;
	logic signed [MSUM_W-1:0]        msum_q;
	logic [MSUM_W-1:0]               msum_mag;
	logic                            mneg_q;
	logic [PRICE_W-1:0]              fast_avg_q;
	logic signed [MACD_W-1:0]        macd_q;
	logic signed [MACD_W-1:0]        sig_q;

	logic                            s_acc;
	logic                            out_free;

	logic [PRICE_W-1:0]              price_rdata;
	logic [MACD_W-1:0]               macd_rdata;

	logic                            div_start;
	logic [DIV_W-1:0]                div_dvd;
	logic [VW-1:0]                   div_dvs;
	logic                            div_done;
	logic [DIV_W-1:0]                div_quo;

	logic [msma_pkg::DEC_W-1:0]      dec_c;

	logic                            m_valid_q;
	logic signed [MACD_W-1:0]        o_macd_q, o_sig_q;
	logic                            o_mv_q, o_sv_q;
	logic [msma_pkg::DEC_W-1:0]      o_dec_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_free      = !m_valid_q || m_axis_tready;

	// Configuration registers; writes to an unknown index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_len_q   <= msma_pkg::FAST_LEN_RST;
			slow_len_q   <= msma_pkg::SLOW_LEN_RST;
			signal_len_q <= msma_pkg::SIGNAL_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				msma_pkg::CFG_FAST_LEN: fast_len_q <= cfg_data;
				msma_pkg::CFG_SLOW_LEN: slow_len_q <= cfg_data;
				msma_pkg::CFG_SIGNAL_LEN: begin
					signal_len_q <= cfg_data[msma_pkg::SIG_LEN_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// Effective lengths: zero acts as one, oversize is clamped to the ring.
	always_comb begin
		if (fast_len_q == '0) begin
			fl_c = LEN_W'(1);
		end else if (32'(fast_len_q) > 32'(MAX_WINDOW)) begin
			fl_c = LEN_W'(MAX_WINDOW);
		end else begin
			fl_c = LEN_W'(fast_len_q);
		end
		if (slow_len_q == '0) begin
			sl_c = LEN_W'(1);
		end else if (32'(slow_len_q) > 32'(MAX_WINDOW)) begin
			sl_c = LEN_W'(MAX_WINDOW);
		end else begin
			sl_c = LEN_W'(slow_len_q);
		end
		if (signal_len_q == '0) begin
			gl_c = GLEN_W'(1);
		end else if (32'(signal_len_q) > 32'(MAX_SIGNAL)) begin
			gl_c = GLEN_W'(MAX_SIGNAL);
		end else begin
			gl_c = GLEN_W'(signal_len_q);
		end
		big_c = (fl_c > sl_c) ? fl_c : sl_c;
		mv_c  = (32'(tick_q) + 32'd1) >= 32'(big_c);
		sv_c  = (32'(tick_q) + 32'd2) >= (32'(big_c) + 32'(gl_c));
	end

	// Window read issue: one RAM word per cycle, data arrives in the following cycle.
	always_comb begin
		if (state_q == ST_PSUM) begin
			issue = (rd_cnt_q < VW'(big_q));
		end else if (state_q == ST_MSUM) begin
			issue = (rd_cnt_q < VW'(gl_q));
		end else begin
			issue = 1'b0;
		end
		sum_done = !issue && !pend_q;
	end

	// Magnitude of the MACD window sum for the unsigned divider.
	assign msum_mag = msum_q[MSUM_W-1] ? MSUM_W'(-msum_q) : MSUM_W'(msum_q);

	// Divider requests from the three division points.
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		unique case (state_q)
			ST_PSUM: begin
				div_start = sum_done;
				div_dvd   = DIV_W'(fast_sum_q);
				div_dvs   = VW'(fl_q);
			end
			ST_DIVF: begin
				div_start = div_done;
				div_dvd   = DIV_W'(slow_sum_q);
				div_dvs   = VW'(sl_q);
			end
			ST_MSUM: begin
				div_start = sum_done;
				div_dvd   = DIV_W'(msum_mag);
				div_dvs   = VW'(gl_q);
			end
			default: ;
		endcase
	end

	// Decision from the finished MACD and signal values.
	always_comb begin
		dec_c = msma_pkg::DEC_HOLD;
		if (mv_q && sv_q) begin
			if (macd_q > 0 && sig_q > 0 && macd_q > sig_q) begin
				dec_c = msma_pkg::DEC_BUY;
			end else if (macd_q < 0 && sig_q < 0 && macd_q < sig_q) begin
				dec_c = msma_pkg::DEC_SELL;
			end
		end
	end

	// Sequencer and its control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phead_q   <= '0;
			mhead_q   <= '0;
			tick_q    <= '0;
			rd_cnt_q  <= '0;
			pend_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			// The result register empties on its transaction unless a new
			// result is loaded in the same cycle.
			if (m_valid_q && m_axis_tready && state_q != ST_OUT) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						rd_cnt_q <= '0;
						pend_q   <= 1'b0;
						state_q  <= mv_c ? ST_PSUM : ST_MWR;
					end
				end
				ST_PSUM, ST_MSUM: begin
					pend_q <= issue;
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (sum_done) begin
						state_q <= (state_q == ST_PSUM) ? ST_DIVF : ST_DIVG;
					end
				end
				ST_DIVF: begin
					if (div_done) begin
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					if (div_done) begin
						state_q <= ST_MWR;
					end
				end
				ST_MWR: begin
					rd_cnt_q <= '0;
					pend_q   <= 1'b0;
					state_q  <= sv_q ? ST_MSUM : ST_OUT;
				end
				ST_DIVG: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						phead_q   <= (32'(phead_q) == MAX_WINDOW - 1) ? '0 : phead_q + 1'b1;
						mhead_q   <= (32'(mhead_q) == MAX_SIGNAL - 1) ? '0 : mhead_q + 1'b1;
						if (32'(tick_q) < TICK_MAX) begin
							tick_q <= tick_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the tick in progress.
	always_ff @(posedge clk) begin
		dk_q <= rd_cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					fl_q       <= fl_c;
					sl_q       <= sl_c;
					big_q      <= big_c;
					gl_q       <= gl_c;
					mv_q       <= mv_c;
					sv_q       <= sv_c;
					fast_sum_q <= '0;
					slow_sum_q <= '0;
					macd_q     <= '0;
					sig_q      <= '0;
					prptr_q    <= phead_q;
				end
			end
			ST_PSUM: begin
				if (issue) begin
					prptr_q <= (prptr_q == '0) ? PAW'(MAX_WINDOW - 1) : prptr_q - 1'b1;
				end
				if (pend_q && dk_q < VW'(fl_q)) begin
					fast_sum_q <= fast_sum_q + SUM_W'(price_rdata);
				end
				if (pend_q && dk_q < VW'(sl_q)) begin
					slow_sum_q <= slow_sum_q + SUM_W'(price_rdata);
				end
			end
			ST_DIVF: begin
				if (div_done) begin
					fast_avg_q <= div_quo[PRICE_W-1:0];
				end
			end
			ST_DIVS: begin
				if (div_done) begin
					macd_q <= $signed({1'b0, fast_avg_q}) -
						$signed({1'b0, div_quo[PRICE_W-1:0]});
				end
			end
			ST_MWR: begin
				mrptr_q <= mhead_q;
				msum_q  <= '0;
			end
			ST_MSUM: begin
				if (issue) begin
					mrptr_q <= (mrptr_q == '0) ? MAW'(MAX_SIGNAL - 1) : mrptr_q - 1'b1;
				end
				if (pend_q) begin
					msum_q <= msum_q + MSUM_W'($signed(macd_rdata));
				end
				mneg_q <= msum_q[MSUM_W-1];
			end
			ST_DIVG: begin
				if (div_done) begin
					sig_q <= mneg_q ? -$signed(div_quo[MACD_W-1:0])
						: $signed(div_quo[MACD_W-1:0]);
				end
			end
			ST_OUT: begin
				if (out_free) begin
					o_macd_q <= macd_q;
					o_sig_q  <= sig_q;
					o_mv_q   <= mv_q;
					o_sv_q   <= sv_q;
					o_dec_q  <= dec_c;
				end
			end
			default: ;
		endcase
	end

	// Price ring: written on the input transaction, read back newest first.
	msma_ram #(
		.WIDTH (PRICE_W),
		.DEPTH (MAX_WINDOW),
		.AW    (PAW)
	) u_price_ram (
		.clk   (clk),
		.we    (s_acc),
		.waddr (phead_q),
		.wdata (s_axis_tdata),
		.raddr (prptr_q),
		.rdata (price_rdata)
	);

	// MACD ring: one entry written per tick, invalid ticks store zero.
	msma_ram #(
		.WIDTH (MACD_W),
		.DEPTH (MAX_SIGNAL),
		.AW    (MAW)
	) u_macd_ram (
		.clk   (clk),
		.we    (state_q == ST_MWR),
		.waddr (mhead_q),
		.wdata (macd_q),
		.raddr (mrptr_q),
		.rdata (macd_rdata)
	);

	// Shared divider for both averages and the signal line.
	msma_div #(
		.DW (DIV_W),
		.VW (VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Output register.
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[msma_pkg::OUT_MACD_LSB +: MACD_W]        = o_macd_q;
		m_axis_tdata[msma_pkg::OUT_SIG_LSB +: MACD_W]         = o_sig_q;
		m_axis_tdata[msma_pkg::OUT_DEC_LSB +: msma_pkg::DEC_W] = o_dec_q;
		m_axis_tuser = '0;
		m_axis_tuser[msma_pkg::USER_MACD_VLD] = o_mv_q;
		m_axis_tuser[msma_pkg::USER_SIG_VLD]  = o_sv_q;
	end

	assign m_axis_tvalid = m_valid_q;

endmodule

@@ rtl/msma_chk.sv @@
// ----------------------------------------------------------------------------
// msma_chk: port-level checks for the MACD crossover indicator
// Watches the result stream and the handshakes of the top level.
// ----------------------------------------------------------------------------
module msma_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [msma_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic [msma_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

	logic [msma_pkg::MACD_W-1:0] macd_f;
	logic [msma_pkg::DEC_W-1:0]  dec_f;
	logic                        mv_f, sv_f;

	assign macd_f = m_axis_tdata[msma_pkg::OUT_MACD_LSB +: msma_pkg::MACD_W];
	assign dec_f  = m_axis_tdata[msma_pkg::OUT_DEC_LSB +: msma_pkg::DEC_W];
	assign mv_f   = m_axis_tuser[msma_pkg::USER_MACD_VLD];
	assign sv_f   = m_axis_tuser[msma_pkg::USER_SIG_VLD];

	// A stalled result transaction stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// A price is taken only once per tick: ready drops after each transaction.
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second price taken while a tick is in progress");

	// Buy or sell only when both values are valid.
	a_dec_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && dec_f != msma_pkg::DEC_HOLD |-> mv_f && sv_f)
		else $error("trade decision without valid values");

	// A full signal window implies full average windows.
	a_sig_needs_macd: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && sv_f |-> mv_f)
		else $error("signal valid without MACD valid");

	// An invalid MACD is reported as zero.
	a_macd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !mv_f |-> macd_f == '0)
		else $error("invalid MACD value is not zero");

endmodule

bind sma_macd_crossover_signal msma_chk u_msma_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

@@ tb/sma_macd_crossover_signal_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_macd_crossover_signal_tb: self-checking bench for the SMA MACD indicator
// Streams prices into the block and predicts every result in the bench:
// MACD, signal line, both valid flags and the decision. The run starts with
// directed price extremes and buy and sell patterns. It then goes through
// phases of random-walk prices under several window settings, including
// out-of-range lengths. Both stream sides idle and stall at random, and one
// long receiver hold backs the block up into its input.
// ----------------------------------------------------------------------------
module sma_macd_crossover_signal_tb;

	localparam int PRICE_W    = msma_pkg::PRICE_W;
	localparam int MACD_W     = msma_pkg::MACD_W;
	localparam int DEC_W      = msma_pkg::DEC_W;
	localparam int CFG_IDX_W  = msma_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = msma_pkg::CFG_DATA_W;
	localparam int WIN_LEN_W  = msma_pkg::WIN_LEN_W;
	localparam int SIG_LEN_W  = msma_pkg::SIG_LEN_W;
	localparam int OUT_DATA_W = msma_pkg::OUT_DATA_W;
	localparam int OUT_USER_W = msma_pkg::OUT_USER_W;

	localparam int WIN_MAX    = 64;
	localparam int SIG_MAX    = 32;
	localparam int TICK_SAT   = WIN_MAX + SIG_MAX - 1;
	localparam int LONG_HOLD  = 600;
	localparam int REPORT_MAX = 200;

	// Index that maps to no register; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic [MACD_W-1:0] macd;
		logic              macd_ok;
		logic [MACD_W-1:0] sig;
		logic              sig_ok;
		logic [DEC_W-1:0]  dec;
	} indicator_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PRICE_W-1:0]    s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Stimulus and checking state.
	logic [PRICE_W-1:0] prices_pending[$];
	indicator_out_t     results_due[$];
	int unsigned        mismatches = 0;
	bit                 no_idle = 1'b0;
	logic               hold_req = 1'b0;
	int unsigned        tx_wait = 0;
	int unsigned        rx_wait = 0;
	int unsigned        long_hold = 0;
	longint             walk_price = 64'd6553600;
	longint             walk_trend = 0;
	int unsigned        trend_left = 0;

	// Predicted indicator state.
	logic [WIN_LEN_W-1:0] fast_len_q = msma_pkg::FAST_LEN_RST;
	logic [WIN_LEN_W-1:0] slow_len_q = msma_pkg::SLOW_LEN_RST;
	logic [SIG_LEN_W-1:0] sig_len_q  = msma_pkg::SIGNAL_LEN_RST;
	logic [PRICE_W-1:0]   price_hist[WIN_MAX];
	longint               macd_hist[SIG_MAX];
	int unsigned          price_head = 0;
	int unsigned          macd_head = 0;
	int unsigned          tick_q = 0;

	sma_macd_crossover_signal #(
		.MAX_WINDOW(WIN_MAX),
		.MAX_SIGNAL(SIG_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#15_000_000;
		$display("FAIL");
		$finish;
	end

	// A length of zero acts as one, and lengths saturate at the ring depth.
	function automatic int unsigned eff_len(input int unsigned v, input int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint unsigned price_window_total(input int unsigned len);
		longint unsigned total;
		int unsigned     idx;
		total = 0;
		idx = price_head;
		for (int unsigned k = 0; k < len; k++) begin
			total += price_hist[idx];
			idx = (idx == 0) ? WIN_MAX - 1 : idx - 1;
		end
		return total;
	endfunction

	function automatic int unsigned draw_idle();
		return no_idle ? 0 : $urandom_range(0, 10);
	endfunction

	// Queues one price for the driver.
	function automatic void queue_price(input logic [PRICE_W-1:0] price);
		prices_pending.insert(prices_pending.size(), price);
	endfunction

	// Works out the result of one accepted price and advances the state.
	task automatic predict_indicator(input logic [PRICE_W-1:0] price);
		int unsigned     fl, sl, gl, big, idx;
		longint unsigned fast_total, slow_total;
		longint          macd, sig, macd_total;
		bit              mv, sv;
		indicator_out_t  r;
		fl = eff_len(fast_len_q, WIN_MAX);
		sl = eff_len(slow_len_q, WIN_MAX);
		gl = eff_len(sig_len_q, SIG_MAX);
		big = (fl > sl) ? fl : sl;
		mv = (tick_q + 1 >= big);
		sv = (tick_q + 2 >= big + gl);
		macd = 0;
		sig = 0;
		price_hist[price_head] = price;
		if (mv) begin
			fast_total = price_window_total(fl);
			slow_total = price_window_total(sl);
			macd = longint'(fast_total / fl) - longint'(slow_total / sl);
		end
		macd_hist[macd_head] = macd;
		// Signal line: signed average over the newest MACD values, toward zero.
		if (sv) begin
			macd_total = 0;
			idx = macd_head;
			for (int unsigned k = 0; k < gl; k++) begin
				macd_total += macd_hist[idx];
				idx = (idx == 0) ? SIG_MAX - 1 : idx - 1;
			end
			sig = macd_total / longint'(gl);
		end
		r.dec = msma_pkg::DEC_HOLD;
		if (mv && sv) begin
			if (macd > 0 && sig > 0 && macd > sig)
				r.dec = msma_pkg::DEC_BUY;
			else if (macd < 0 && sig < 0 && macd < sig)
				r.dec = msma_pkg::DEC_SELL;
		end
		r.macd = macd[MACD_W-1:0];
		r.macd_ok = mv;
		r.sig = sig[MACD_W-1:0];
		r.sig_ok = sv;
		results_due.insert(results_due.size(), r);
		price_head = (price_head + 1 >= WIN_MAX) ? 0 : price_head + 1;
		macd_head = (macd_head + 1 >= SIG_MAX) ? 0 : macd_head + 1;
		if (tick_q < TICK_SAT)
			tick_q++;
	endtask

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endtask

	// One configuration transaction; the prediction follows at the handshake.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			msma_pkg::CFG_FAST_LEN: begin
				fast_len_q = val;
			end
			msma_pkg::CFG_SLOW_LEN: begin
				slow_len_q = val;
			end
			msma_pkg::CFG_SIGNAL_LEN: begin
				sig_len_q = val[SIG_LEN_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	// Waits until every queued price is sent and every predicted result has come back.
	task automatic drain();
		while (prices_pending.size() != 0 || s_axis_tvalid || results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// One phase: new window lengths, then a run of trending random-walk prices
	// with an occasional wild price mixed in.
	task automatic run_phase(input logic [CFG_DATA_W-1:0] f_len,
			input logic [CFG_DATA_W-1:0] s_len, input logic [CFG_DATA_W-1:0] g_len,
			input int unsigned count, input bit quiet, input bit with_hold);
		write_reg(msma_pkg::CFG_FAST_LEN, f_len);
		write_reg(msma_pkg::CFG_SLOW_LEN, s_len);
		write_reg(msma_pkg::CFG_SIGNAL_LEN, g_len);
		no_idle = quiet;
		@(negedge clk);
		for (int unsigned n = 0; n < count; n++) begin
			if (trend_left == 0) begin
				walk_trend = longint'($urandom_range(0, 8192)) - 4096;
				trend_left = $urandom_range(5, 30);
			end
			trend_left--;
			walk_price += walk_trend + longint'($urandom_range(0, 2048)) - 1024;
			if (walk_price < 0)
				walk_price = 0;
			else if (walk_price > 64'hFFFF_FFFF)
				walk_price = 64'hFFFF_FFFF;
			if ($urandom_range(0, 19) == 0)
				queue_price($urandom);
			else
				queue_price(walk_price[PRICE_W-1:0]);
		end
		// Ask the receiver for a long hold while prices keep coming.
		if (with_hold) begin
			@(posedge clk);
			hold_req <= 1'b1;
			@(posedge clk);
			hold_req <= 1'b0;
		end
		drain();
	endtask

	// Price driver: offers queued prices with a random gap after each transaction unless idling is off.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			tx_wait = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_indicator(s_axis_tdata);
				tx_wait = draw_idle();
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// Keep offering the same price.
			end else if (tx_wait > 0) begin
				tx_wait--;
				s_axis_tvalid <= 1'b0;
			end else if (prices_pending.size() != 0) begin
				s_axis_tdata <= prices_pending.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: stalls each result for a random count of valid cycles unless idling is off,
	// and once for a long fixed stretch on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait = 0;
			long_hold = 0;
		end else begin
			if (hold_req)
				long_hold = LONG_HOLD;
			else if (long_hold > 0)
				long_hold--;
			if (m_axis_tvalid && m_axis_tready)
				rx_wait = draw_idle();
			else if (m_axis_tvalid && rx_wait > 0)
				rx_wait--;
			m_axis_tready <= (long_hold == 0) && (rx_wait == 0);
		end
	end

	// Result monitor: compares every result transaction with the oldest prediction.
	always @(posedge clk) begin
		indicator_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t ns: unexpected result, expected none, actual tdata %h tuser %b",
						$time, m_axis_tdata, m_axis_tuser);
			end else begin
				want = results_due.pop_front();
				check_field("macd_value", want.macd,
					m_axis_tdata[msma_pkg::OUT_MACD_LSB +: MACD_W]);
				check_field("signal_value", want.sig,
					m_axis_tdata[msma_pkg::OUT_SIG_LSB +: MACD_W]);
				check_field("decision", want.dec,
					m_axis_tdata[msma_pkg::OUT_DEC_LSB +: DEC_W]);
				check_field("tdata padding", '0,
					m_axis_tdata[OUT_DATA_W-1:msma_pkg::OUT_DEC_LSB+DEC_W]);
				check_field("macd_valid", want.macd_ok,
					m_axis_tuser[msma_pkg::USER_MACD_VLD]);
				check_field("signal_valid", want.sig_ok,
					m_axis_tuser[msma_pkg::USER_SIG_VLD]);
			end
		end
	end

	// Test sequence.
	initial begin
		logic [CFG_DATA_W-1:0] f_len, s_len, g_len;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Price extremes while the reset-length windows are still filling.
		@(negedge clk);
		queue_price(32'h0000_0000);
		queue_price(32'hFFFF_FFFF);
		queue_price(32'hAAAA_AAAA);
		queue_price(32'h5555_5555);
		drain();

		// Shortest windows: extreme MACD swings, then an accelerating rise
		// for buy and an accelerating fall for sell.
		write_reg(msma_pkg::CFG_FAST_LEN, 7'd1);
		write_reg(msma_pkg::CFG_SLOW_LEN, 7'd2);
		write_reg(msma_pkg::CFG_SIGNAL_LEN, 7'd2);
		write_reg(CFG_UNUSED, 7'h7F);
		@(negedge clk);
		queue_price(32'h0000_0000);
		queue_price(32'hFFFF_FFFF);
		queue_price(32'h0000_0000);
		for (int unsigned k = 0; k < 7; k++)
			queue_price(32'h0010_0000 + k * k * 32'h4000);
		for (int unsigned k = 0; k < 7; k++)
			queue_price(32'h0020_0000 - k * k * 32'h4000);
		drain();

		// Random phases over zero, oversized, reset and random lengths.
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin
					f_len = 7'd0;
					s_len = 7'd0;
					g_len = 7'd0;
				end
				1: begin
					f_len = 7'd127;
					s_len = 7'd127;
					g_len = 7'd127;
				end
				2: begin
					f_len = msma_pkg::FAST_LEN_RST;
					s_len = msma_pkg::SLOW_LEN_RST;
					g_len = CFG_DATA_W'(msma_pkg::SIGNAL_LEN_RST);
				end
				3: begin
					f_len = 7'd64;
					s_len = 7'd1;
					g_len = 7'd32;
				end
				4: begin
					f_len = 7'd5;
					s_len = 7'd20;
					g_len = 7'd64;
				end
				9: begin
					f_len = CFG_DATA_W'($urandom_range(0, 127));
					s_len = CFG_DATA_W'($urandom_range(0, 127));
					g_len = CFG_DATA_W'($urandom_range(0, 127));
				end
				default: begin
					f_len = CFG_DATA_W'($urandom_range(1, 16));
					s_len = CFG_DATA_W'($urandom_range(1, 40));
					g_len = CFG_DATA_W'($urandom_range(1, 12));
				end
			endcase
			run_phase(f_len, s_len, g_len, 45, (ph % 3 == 1), (ph == 2));
		end

		drain();
		repeat (250) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/msma_pkg.sv
rtl/msma_ram.sv
rtl/msma_div.sv
rtl/sma_macd_crossover_signal.sv
rtl/msma_chk.sv
tb/sma_macd_crossover_signal_tb.sv
